FILE: sv/interrupt_number_bitmap_allocator_macros.svh
// Assertion macros shared by the interrupt number bitmap allocator.
`ifndef INTERRUPT_NUMBER_BITMAP_ALLOCATOR_MACROS_SVH
`define INTERRUPT_NUMBER_BITMAP_ALLOCATOR_MACROS_SVH

// Checked only outside reset.
`define IBMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IBMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/ibma_pkg.sv
// Package with types and constants of the interrupt number bitmap allocator.
package ibma_pkg;

  localparam int unsigned WORD_SHIFT = 5;
  localparam logic [31:0] BIT_MASK   = 32'h1F;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        act;
    logic        cmd;
    logic        found;
    logic [31:0] grant;
  } tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

FILE: sv/ibma_cell.sv
// One map word of the allocator with its search and free logic.
module ibma_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic [31:0]        num,
  input  logic [31:0]        offset,
  input  ibma_pkg::tok_t     tok_i,
  output ibma_pkg::tok_t     tok_o
);

  localparam logic [31:0] WORD_BASE = 32'(IDX) << ibma_pkg::WORD_SHIFT;

  logic [31:0]    used_r;
  logic [31:0]    used_nxt;
  logic [31:0]    start_r;
  logic [31:0]    start_nxt;
  ibma_pkg::tok_t tok_r;
  ibma_pkg::tok_t tok_nxt;

  logic [32:0] diff;
  logic [31:0] neg;
  logic [5:0]  lo1;
  logic [5:0]  wrapb;
  logic [6:0]  lo2;
  logic        big;
  logic [31:0] ok;
  logic [31:0] avail;
  logic [4:0]  hit_b;
  logic        hit;
  logic        match;

  always_comb begin
    diff = {1'b0, num} - {1'b0, start_r};
    neg  = 32'd0 - start_r;
    if (diff[32]) begin
      lo1 = 6'd0;
    end else if (diff[31:5] != 27'd0) begin
      lo1 = 6'd32;
    end else begin
      lo1 = {1'b0, diff[4:0]};
    end
    if ((neg == 32'd0) || (neg[31:5] != 27'd0)) begin
      wrapb = 6'd32;
    end else begin
      wrapb = {1'b0, neg[4:0]};
    end
    big = |num[31:5];
    lo2 = {1'b0, wrapb} + {2'b00, num[4:0]};
    for (int b = 0; b < 32; b++) begin
      if (6'(b) < wrapb) begin
        ok[b] = 6'(b) >= lo1;
      end else begin
        ok[b] = !big && (7'(b) >= lo2);
      end
    end
    avail = ~used_r & ok;
    hit   = |avail;
    hit_b = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (avail[b]) begin
        hit_b = 5'(b);
      end
    end
    match = offset[31:5] == 27'(IDX);
  end

  always_comb begin
    used_nxt  = used_r;
    tok_nxt   = tok_i;
    start_nxt = cfg_we ? (cfg_data + WORD_BASE) : start_r;
    if (tok_i.act) begin
      unique case (tok_i.cmd)
        ibma_pkg::CMD_ALLOC: begin
          if (!tok_i.found && hit) begin
            used_nxt[hit_b] = 1'b1;
            tok_nxt.found   = 1'b1;
            tok_nxt.grant   = start_r + {27'd0, hit_b};
          end
        end
        ibma_pkg::CMD_FREE: begin
          if (match) begin
            used_nxt[offset[4:0]] = 1'b0;
          end
        end
        default: begin
          tok_nxt = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      start_r <= WORD_BASE;
      tok_r   <= '0;
    end else begin
      used_r  <= used_nxt;
      start_r <= start_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: sv/interrupt_number_bitmap_allocator.sv
// Top level of the interrupt number bitmap allocator: a chain of map word cells.
//
//   channel  direction  handshake            payload
//   in_      in         in_valid / in_stall  in_command, in_irq_number
//   out_     out        out_valid / out_stall out_granted_number, out_success
//   cfg_     in         cfg_valid / cfg_ready cfg_base_number
//
// From accept to result, the input register loads the command beat, the beat walks the chain
// of word cells one cell per cycle, and the last cell loads the output register.
// Reset clears every map word, sets the base number to zero and empties the chain.
// A new item is accepted once the chain has drained and no stalled result waits.
// A stalled result holds in the output register; the chain never stalls.
`include "interrupt_number_bitmap_allocator_macros.svh"

module interrupt_number_bitmap_allocator #(
  parameter int unsigned MAP_WORDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_irq_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_granted_number,
  output logic        out_success,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_base_number
);

  ibma_pkg::state_t state_r;
  ibma_pkg::state_t state_nxt;

  logic [31:0]    base_r;
  logic [31:0]    num_r;
  logic [31:0]    offset_r;
  ibma_pkg::tok_t tok0_r;
  ibma_pkg::tok_t tok_w [MAP_WORDS+1];
  ibma_pkg::tok_t tok_end;
  logic [MAP_WORDS:0] act_vec;

  logic        out_valid_r;
  logic [31:0] out_granted_r;
  logic        out_success_r;

  logic in_acc;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_stall  = (state_r == ibma_pkg::ST_SCAN) | (out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;

  assign tok_w[0] = tok0_r;
  assign tok_end  = tok_w[MAP_WORDS];

  for (genvar i = 0; i < MAP_WORDS; i++) begin : g_cell
    ibma_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg_we  (cfg_we),
      .cfg_data(cfg_base_number),
      .num     (num_r),
      .offset  (offset_r),
      .tok_i   (tok_w[i]),
      .tok_o   (tok_w[i+1])
    );
  end

  for (genvar i = 0; i <= MAP_WORDS; i++) begin : g_act
    assign act_vec[i] = tok_w[i].act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ibma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ibma_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ibma_pkg::ST_SCAN;
        end
      end
      ibma_pkg::ST_SCAN: begin
        if (tok_end.act) begin
          state_nxt = ibma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ibma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      tok0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_base_number;
      end
      tok0_r.act   <= in_acc;
      tok0_r.cmd   <= in_command;
      tok0_r.found <= 1'b0;
      tok0_r.grant <= '0;
      if (tok_end.act) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      num_r    <= in_irq_number;
      offset_r <= in_irq_number - base_r;
    end
    if (tok_end.act) begin
      out_granted_r <= tok_end.grant;
      out_success_r <= (tok_end.cmd == ibma_pkg::CMD_FREE) | tok_end.found;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_number = out_granted_r;
  assign out_success        = out_success_r;

  `IBMA_ASSERT(a_one_beat_in_chain, $onehot0(act_vec), "more than one command beat in the chain")
  `IBMA_ASSERT(a_accept_starts_scan, in_acc |=> (tok0_r.act && (state_r == ibma_pkg::ST_SCAN)), "accepted item did not enter the chain")
  `IBMA_ASSERT(a_result_slot_free, tok_end.act |-> !out_valid_r, "chain result arrived while output register was full")
  `IBMA_ASSERT_ALWAYS(a_fail_grants_zero, (rst_n && out_valid_r && !out_success_r) |-> (out_granted_r == 32'd0), "failed allocation with nonzero number")

endmodule

FILE: sim/tb_interrupt_number_bitmap_allocator.sv
// Self-checking testbench for the interrupt number bitmap allocator.
`timescale 1ns / 100ps

module tb_interrupt_number_bitmap_allocator;

  localparam int MAP_WORDS  = 4;
  localparam int MAP_BITS   = MAP_WORDS * 32;
  localparam int SETTLE     = MAP_WORDS + 6;
  localparam int QUIET_MAX  = 5000;
  localparam int PHASE_LEN  = 190;

  typedef struct packed {
    logic [31:0] granted;
    logic        success;
  } grant_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTY,
    STALL_PERIODIC
  } stall_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [31:0] in_irq_number;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_granted_number;
  logic        out_success;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_base_number;

  logic [31:0]   used_bits [MAP_WORDS];
  logic [31:0]   base_q;
  grant_result_t expected_grants [$];
  int            error_count;
  stall_mode_t   stall_mode;
  logic          stall_hold;
  int            stall_run;
  int            stall_tick;
  bit            gaps_on;
  int            burst_left;

  interrupt_number_bitmap_allocator #(
    .MAP_WORDS(MAP_WORDS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_irq_number      (in_irq_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted_number (out_granted_number),
    .out_success        (out_success),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_base_number    (cfg_base_number)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic grant_result_t apply_command(input logic cmd, input logic [31:0] num);
    grant_result_t res;
    logic [31:0]   cand;
    logic [31:0]   offset;
    bit            found;
    res.granted = '0;
    res.success = 1'b0;
    found = 0;
    if (cmd == ibma_pkg::CMD_ALLOC) begin
      for (int w = 0; w < MAP_WORDS && !found; w++) begin
        for (int b = 0; b < 32 && !found; b++) begin
          cand = base_q + 32'((w << ibma_pkg::WORD_SHIFT) + b);
          if (!used_bits[w][b] && cand >= num) begin
            used_bits[w][b] = 1'b1;
            res.granted = cand;
            res.success = 1'b1;
            found = 1;
          end
        end
      end
    end else begin
      offset = num - base_q;
      if ((offset >> ibma_pkg::WORD_SHIFT) < MAP_WORDS) begin
        used_bits[offset >> ibma_pkg::WORD_SHIFT][offset & ibma_pkg::BIT_MASK] = 1'b0;
      end
      res.success = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : beat_monitor
    grant_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        base_q = cfg_base_number;
      end
      if (in_valid && !in_stall) begin
        expected_grants.push_back(apply_command(in_command, in_irq_number));
      end
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected result beat: granted_number %h success %b",
                 out_granted_number, out_success);
          error_count++;
        end else begin
          want = expected_grants.pop_front();
          if (out_granted_number !== want.granted) begin
            $error("granted_number: expected %h, actual %h", want.granted, out_granted_number);
            error_count++;
          end
          if (out_success !== want.success) begin
            $error("success: expected %b, actual %b", want.success, out_success);
            error_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    stall_tick++;
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      STALL_BURSTY: begin
        if (stall_run == 0) begin
          stall_hold = ~stall_hold;
          stall_run = $urandom_range(1, 12);
        end
        stall_run--;
        out_stall <= stall_hold;
      end
      default: begin
        out_stall <= (stall_tick % 7) < 3;
      end
    endcase
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_beat(input logic cmd, input logic [31:0] num);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_irq_number <= num;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_base_number <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_low_numbers_and_free();
    send_beat(ibma_pkg::CMD_ALLOC, 32'd0);
    send_beat(ibma_pkg::CMD_ALLOC, 32'd0);
    send_beat(ibma_pkg::CMD_ALLOC, 32'd5);
    send_beat(ibma_pkg::CMD_ALLOC, 32'd40);
    send_beat(ibma_pkg::CMD_ALLOC, 32'd127);
    send_beat(ibma_pkg::CMD_ALLOC, 32'd128);
    send_beat(ibma_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    send_beat(ibma_pkg::CMD_FREE, 32'd1);
    send_beat(ibma_pkg::CMD_ALLOC, 32'd0);
    send_beat(ibma_pkg::CMD_FREE, 32'd3);
    send_beat(ibma_pkg::CMD_FREE, 32'd128);
    send_beat(ibma_pkg::CMD_FREE, 32'hFFFF_FFFF);
    send_beat(ibma_pkg::CMD_FREE, 32'd40);
    send_beat(ibma_pkg::CMD_ALLOC, 32'd33);
  endtask

  task automatic test_wrapping_base();
    write_base(32'hFFFF_FFF0);
    send_beat(ibma_pkg::CMD_ALLOC, 32'd0);
    send_beat(ibma_pkg::CMD_ALLOC, 32'hFFFF_FFF5);
    send_beat(ibma_pkg::CMD_ALLOC, 32'h0000_0010);
    send_beat(ibma_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    send_beat(ibma_pkg::CMD_FREE, 32'h0000_006F);
    send_beat(ibma_pkg::CMD_ALLOC, 32'h0000_006F);
    send_beat(ibma_pkg::CMD_FREE, 32'h0000_0070);
    write_base(32'hFFFF_FFFF);
    send_beat(ibma_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(input logic [31:0] base, input int alloc_pct,
                                     input stall_mode_t mode, input bit gaps);
    int          pick;
    int          off;
    logic [31:0] num;
    write_base(base);
    stall_mode = mode;
    gaps_on    = gaps;
    burst_left = 0;
    for (int i = 0; i < PHASE_LEN; i++) begin
      if (i == PHASE_LEN / 2) begin
        wait_idle();
      end
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        if ($urandom_range(0, 9) < 8) begin
          num = base_q + 32'($urandom_range(0, MAP_BITS + 15)) - 32'd8;
        end else begin
          case ($urandom_range(0, 2))
            0: num = 32'd0;
            1: num = 32'hFFFF_FFFF;
            default: num = $urandom;
          endcase
        end
        send_beat(ibma_pkg::CMD_ALLOC, num);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          off = $urandom_range(0, MAP_BITS - 1);
          repeat (3) begin
            if (!used_bits[off >> ibma_pkg::WORD_SHIFT][off & ibma_pkg::BIT_MASK]) begin
              off = $urandom_range(0, MAP_BITS - 1);
            end
          end
          num = base_q + 32'(off);
        end else if (pick < 90) begin
          num = base_q + 32'(MAP_BITS) + 32'($urandom_range(0, 64));
        end else begin
          num = $urandom;
        end
        send_beat(ibma_pkg::CMD_FREE, num);
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = ibma_pkg::CMD_ALLOC;
    in_irq_number   = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_base_number = '0;
    base_q          = '0;
    error_count     = 0;
    stall_mode      = STALL_NONE;
    stall_hold      = 1'b0;
    stall_run       = 0;
    stall_tick      = 0;
    gaps_on         = 0;
    burst_left      = 0;
    for (int w = 0; w < MAP_WORDS; w++) begin
      used_bits[w] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_low_numbers_and_free();
    test_wrapping_base();
    test_random_traffic(32'h0000_0000, 55, STALL_NONE, 0);
    test_random_traffic(32'hFFFF_FFFF, 60, STALL_RANDOM, 1);
    test_random_traffic(32'hFFFF_FFC0, 50, STALL_BURSTY, 1);
    test_random_traffic(32'h8000_0000, 70, STALL_PERIODIC, 1);
    test_random_traffic($urandom, 40, STALL_RANDOM, 1);
    test_random_traffic(32'hFFFF_FF80, 55, STALL_BURSTY, 0);
    test_random_traffic(32'd100, 65, STALL_NONE, 1);
    test_random_traffic($urandom, 45, STALL_PERIODIC, 1);

    wait_idle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
